// ===== sv/cfs_pkg.sv =====
package cfs_pkg;

	localparam int FREQ_W   = 20;
	localparam int CAR_W    = 21;
	localparam int CUR_W    = 16;
	localparam int GAIN_W   = 16;
	localparam int OUT_W    = 24;
	localparam int CFG_W    = 41;
	localparam int IDX_W    = 3;
	localparam int SPAN_W   = 20;
	localparam int QUO_W    = 21;
	localparam int PROD_W   = SPAN_W + CAR_W;
	localparam int BPROD_W  = GAIN_W + CUR_W;
	localparam int BOOST_SH = 6;
	localparam int BOOST_W  = BPROD_W - BOOST_SH;
	localparam int NUM_BP_DEFAULT = 6;
	localparam int NUM_BP_SLOTS   = 6;

	localparam logic [IDX_W-1:0] CFG_IDX_GAIN = 3'd6;

	// One segment lookup, ready for the multiply and divide.
	typedef struct packed {
		logic [CAR_W-1:0]  base;
		logic              neg;
		logic [SPAN_W-1:0] dx;
		logic [CAR_W-1:0]  dcmag;
		logic [SPAN_W-1:0] span;
		logic              boost_en;
		logic [CUR_W-1:0]  imax;
	} seg_t;

	// Values that ride alongside the divider.
	typedef struct packed {
		logic              neg;
		logic [CAR_W-1:0]  base;
		logic [BOOST_W-1:0] boost;
	} side_t;

endpackage

// ===== sv/cfs_segment.sv =====
module cfs_segment #(
	parameter int NB = cfs_pkg::NUM_BP_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_in,
	input  logic signed [cfs_pkg::FREQ_W-1:0] elec_freq,
	input  logic signed [cfs_pkg::CUR_W-1:0]  current_u,
	input  logic signed [cfs_pkg::CUR_W-1:0]  current_v,
	input  logic signed [cfs_pkg::CUR_W-1:0]  current_w,
	input  logic                              currents_valid,
	input  logic signed [cfs_pkg::FREQ_W-1:0] bp_freq [NB],
	input  logic        [cfs_pkg::CAR_W-1:0]  bp_car [NB],
	output logic                              valid_s1,
	output logic                              valid_s2,
	output cfs_pkg::seg_t                     seg_s2
);

	logic [NB-1:0] run, le;
	logic [NB-1:0] run_s1, le_s1;
	logic signed [cfs_pkg::FREQ_W-1:0] fe_s1;
	logic signed [cfs_pkg::CUR_W-1:0]  cu_s1, cv_s1, cw_s1;
	logic cval_s1;

	always_comb begin
		for (int i = 0; i < NB; i++) begin
			le[i] = (elec_freq <= bp_freq[i]);
			if (i == 0) begin
				run[i] = (bp_car[i] != '0);
			end else begin
				run[i] = run[i-1] && (bp_car[i] != '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in && run[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			run_s1  <= run;
			le_s1   <= le;
			fe_s1   <= elec_freq;
			cu_s1   <= current_u;
			cv_s1   <= current_v;
			cw_s1   <= current_w;
			cval_s1 <= currents_valid;
		end
	end

	// Stage two: pick the segment with one-hot selects.
	logic [NB-1:0] first_oh, last_oh;
	logic found;
	logic signed [cfs_pkg::FREQ_W-1:0] f_hi, f_lo;
	logic [cfs_pkg::CAR_W-1:0] c_hi, c_lo, c_last;
	logic signed [cfs_pkg::FREQ_W:0]  span_w, dx_w;
	logic signed [cfs_pkg::CAR_W:0]   dc_w;
	logic [cfs_pkg::CAR_W:0] dc_abs;
	logic [cfs_pkg::CUR_W:0] mu, mv, mw, mmax;
	cfs_pkg::seg_t seg;

	always_comb begin
		found  = 1'b0;
		f_hi   = '0;
		f_lo   = '0;
		c_hi   = '0;
		c_lo   = '0;
		c_last = '0;
		first_oh = '0;
		last_oh  = '0;
		for (int i = 1; i < NB; i++) begin
			first_oh[i] = run_s1[i] && le_s1[i] && !found;
			found = found || (run_s1[i] && le_s1[i]);
		end
		for (int i = 0; i < NB; i++) begin
			if (i == NB - 1) begin
				last_oh[i] = run_s1[i];
			end else begin
				last_oh[i] = run_s1[i] && !run_s1[i+1];
			end
			if (last_oh[i]) begin
				c_last = c_last | bp_car[i];
			end
		end
		for (int i = 1; i < NB; i++) begin
			if (first_oh[i]) begin
				f_hi = f_hi | bp_freq[i];
				f_lo = f_lo | bp_freq[i-1];
				c_hi = c_hi | bp_car[i];
				c_lo = c_lo | bp_car[i-1];
			end
		end
		span_w = {f_hi[cfs_pkg::FREQ_W-1], f_hi} - {f_lo[cfs_pkg::FREQ_W-1], f_lo};
		dx_w   = {fe_s1[cfs_pkg::FREQ_W-1], fe_s1} - {f_lo[cfs_pkg::FREQ_W-1], f_lo};
		dc_w   = $signed({1'b0, c_hi}) - $signed({1'b0, c_lo});
		dc_abs = dc_w[cfs_pkg::CAR_W] ? (~dc_w + 1'b1) : dc_w;

		seg.base  = bp_car[0];
		seg.neg   = 1'b0;
		seg.dx    = '0;
		seg.dcmag = '0;
		seg.span  = cfs_pkg::SPAN_W'(1);
		if (!le_s1[0]) begin
			if (!found) begin
				seg.base = c_last;
			end else if (span_w > 0) begin
				seg.base  = c_lo;
				seg.neg   = dc_w[cfs_pkg::CAR_W];
				seg.dx    = dx_w[cfs_pkg::SPAN_W-1:0];
				seg.dcmag = dc_abs[cfs_pkg::CAR_W-1:0];
				seg.span  = span_w[cfs_pkg::SPAN_W-1:0];
			end else begin
				seg.base = c_hi;
			end
		end

		mu = cu_s1[cfs_pkg::CUR_W-1] ? (~{cu_s1[cfs_pkg::CUR_W-1], cu_s1} + 1'b1)
			: {1'b0, cu_s1};
		mv = cv_s1[cfs_pkg::CUR_W-1] ? (~{cv_s1[cfs_pkg::CUR_W-1], cv_s1} + 1'b1)
			: {1'b0, cv_s1};
		mw = cw_s1[cfs_pkg::CUR_W-1] ? (~{cw_s1[cfs_pkg::CUR_W-1], cw_s1} + 1'b1)
			: {1'b0, cw_s1};
		mmax = (mu > mv) ? mu : mv;
		if (mw > mmax) begin
			mmax = mw;
		end
		seg.imax     = mmax[cfs_pkg::CUR_W-1:0];
		seg.boost_en = cval_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s2 <= seg;
		end
	end

endmodule

// ===== sv/cfs_divider.sv =====
module cfs_divider #(
	parameter int SIDE_W = $bits(cfs_pkg::side_t)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_in,
	input  logic [cfs_pkg::PROD_W-1:0]        num,
	input  logic [cfs_pkg::SPAN_W-1:0]        den,
	input  logic [SIDE_W-1:0]                 side_in,
	output logic                              valid_out,
	output logic [cfs_pkg::QUO_W-1:0]         quo,
	output logic [SIDE_W-1:0]                 side_out
);

	localparam int QW = cfs_pkg::QUO_W;
	localparam int NW = cfs_pkg::PROD_W;

	// Restoring division, one quotient bit per stage, most significant first.
	logic          vld_s  [QW+1];
	logic [NW-1:0] rem_s  [QW+1];
	logic [cfs_pkg::SPAN_W-1:0] den_s [QW+1];
	logic [QW-1:0] quo_s  [QW+1];
	logic [SIDE_W-1:0] side_s [QW+1];

	assign vld_s[0]  = valid_in;
	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic [NW:0] trial;
		logic [QW-1:0] qn;

		always_comb begin
			trial = {1'b0, rem_s[k]} - ((NW+1)'(den_s[k]) << B);
			qn    = quo_s[k];
			qn[B] = !trial[NW];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= trial[NW] ? rem_s[k] : trial[NW-1:0];
				den_s[k+1]  <= den_s[k];
				quo_s[k+1]  <= qn;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign valid_out = vld_s[QW];
	assign quo       = quo_s[QW];
	assign side_out  = side_s[QW];

endmodule

// ===== sv/carrier_frequency_schedule_core.sv =====
// Carrier frequency schedule: a piecewise-linear lookup of the PWM carrier
// against electrical frequency over up to NUM_BREAKPOINTS breakpoints, plus
// a boost of gain times the largest phase current, saturated to 24 bits.
// The block is a fully pipelined datapath that takes one beat per cycle
// while the output is not stalled; it has two lookup stages, one multiply
// stage, 21 stages of a restoring divider at one quotient bit each, and the
// output register. With an empty table (first carrier zero) a beat yields
// no result. The whole pipeline halts while the output is stalled. The
// user must write registers only with no beat in flight; nothing enforces it.
module carrier_frequency_schedule_core #(
	parameter int NUM_BREAKPOINTS = cfs_pkg::NUM_BP_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [cfs_pkg::FREQ_W-1:0] elec_freq,
	input  logic signed [cfs_pkg::CUR_W-1:0]  current_u,
	input  logic signed [cfs_pkg::CUR_W-1:0]  current_v,
	input  logic signed [cfs_pkg::CUR_W-1:0]  current_w,
	input  logic                              currents_valid,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cfs_pkg::OUT_W-1:0]         carrier_freq,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cfs_pkg::IDX_W-1:0]         cfg_index,
	input  logic [cfs_pkg::CFG_W-1:0]         cfg_data
);

	localparam int NB = NUM_BREAKPOINTS;

	logic signed [cfs_pkg::FREQ_W-1:0] bp_freq [NB];
	logic        [cfs_pkg::CAR_W-1:0]  bp_car  [NB];
	logic        [cfs_pkg::GAIN_W-1:0] gain_q;
	logic en;

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;

	for (genvar i = 0; i < NB; i++) begin : g_bp
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				bp_freq[i] <= '0;
				bp_car[i]  <= '0;
			end else if (cfg_valid && cfg_index == cfs_pkg::IDX_W'(i)) begin
				bp_freq[i] <= cfg_data[cfs_pkg::FREQ_W-1:0];
				bp_car[i]  <= cfg_data[cfs_pkg::CFG_W-1:cfs_pkg::FREQ_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
		end else if (cfg_valid && cfg_index == cfs_pkg::CFG_IDX_GAIN) begin
			gain_q <= cfg_data[cfs_pkg::GAIN_W-1:0];
		end
	end

	logic valid_s1, valid_s2;
	cfs_pkg::seg_t seg_s2;

	cfs_segment #(.NB(NB)) u_segment (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.valid_in       (in_valid),
		.elec_freq      (elec_freq),
		.current_u      (current_u),
		.current_v      (current_v),
		.current_w      (current_w),
		.currents_valid (currents_valid),
		.bp_freq        (bp_freq),
		.bp_car         (bp_car),
		.valid_s1       (valid_s1),
		.valid_s2       (valid_s2),
		.seg_s2         (seg_s2)
	);

	// Stage three: interpolation product and boost product.
	logic valid_s3;
	logic [cfs_pkg::PROD_W-1:0]  prod_s3;
	logic [cfs_pkg::SPAN_W-1:0]  span_s3;
	logic [cfs_pkg::BPROD_W-1:0] bprod;
	cfs_pkg::side_t side_s3;

	assign bprod = seg_s2.boost_en ? (gain_q * seg_s2.imax) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3       <= seg_s2.dx * seg_s2.dcmag;
			span_s3       <= seg_s2.span;
			side_s3.neg   <= seg_s2.neg;
			side_s3.base  <= seg_s2.base;
			side_s3.boost <= bprod[cfs_pkg::BPROD_W-1:cfs_pkg::BOOST_SH];
		end
	end

	logic dv_valid;
	logic [cfs_pkg::QUO_W-1:0] dv_quo;
	cfs_pkg::side_t dv_side;

	cfs_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_s3),
		.num       (prod_s3),
		.den       (span_s3),
		.side_in   (side_s3),
		.valid_out (dv_valid),
		.quo       (dv_quo),
		.side_out  (dv_side)
	);

	// Output stage: apply the quotient, floor at zero, add the boost, saturate.
	logic signed [cfs_pkg::CAR_W+1:0] car_sum;
	logic [cfs_pkg::BOOST_W:0] total;
	logic [cfs_pkg::OUT_W-1:0] result;

	always_comb begin
		if (dv_side.neg) begin
			car_sum = $signed({2'b00, dv_side.base}) - $signed({2'b00, dv_quo});
		end else begin
			car_sum = $signed({2'b00, dv_side.base}) + $signed({2'b00, dv_quo});
		end
		if (car_sum < 0) begin
			total = (cfs_pkg::BOOST_W+1)'(dv_side.boost);
		end else begin
			total = (cfs_pkg::BOOST_W+1)'(car_sum[cfs_pkg::CAR_W:0])
				+ (cfs_pkg::BOOST_W+1)'(dv_side.boost);
		end
		if (total[cfs_pkg::BOOST_W:cfs_pkg::OUT_W] != '0) begin
			result = '1;
		end else begin
			result = total[cfs_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carrier_freq <= result;
		end
	end

	// A beat with an empty table never enters the pipeline.
	a_empty_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && bp_car[0] == '0 |=> !valid_s1)
		else $error("beat with empty table entered the pipeline");

	// A downward interpolation never steps below zero.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && dv_side.neg |-> dv_quo <= dv_side.base)
		else $error("interpolated carrier went negative");

	// While the output holds a stalled beat, stages one and three are frozen.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(valid_s1) && $stable(valid_s3))
		else $error("pipeline advanced during a stall");

endmodule

// ===== tb/tb_carrier_frequency_schedule_core.sv =====
module tb_carrier_frequency_schedule_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 40;
	localparam longint CYCLE_LIMIT = 600000;

	class carrier_scoreboard;
		logic [cfs_pkg::CFG_W-1:0]  bp[cfs_pkg::NUM_BP_SLOTS];
		logic [cfs_pkg::GAIN_W-1:0] gain;
		logic [cfs_pkg::OUT_W-1:0]  carrier_q[$];
		int                         errors;

		function new();
			foreach (bp[i]) bp[i] = '0;
			gain = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [cfs_pkg::IDX_W-1:0] idx,
				logic [cfs_pkg::CFG_W-1:0] data);
			if (idx < cfs_pkg::CFG_IDX_GAIN) bp[idx] = data;
			else if (idx == cfs_pkg::CFG_IDX_GAIN) gain = data[cfs_pkg::GAIN_W-1:0];
		endfunction

		function longint freq_of(int i);
			return longint'($signed(bp[i][cfs_pkg::FREQ_W-1:0]));
		endfunction

		function longint car_of(int i);
			return longint'(bp[i][cfs_pkg::CFG_W-1:cfs_pkg::FREQ_W]);
		endfunction

		function longint mag(logic [cfs_pkg::CUR_W-1:0] c);
			longint s;
			s = longint'($signed(c));
			return (s < 0) ? -s : s;
		endfunction

		// Expected carrier for one accepted beat; an empty table yields nothing.
		function void note_input(logic [cfs_pkg::FREQ_W-1:0] fe_in,
				logic [cfs_pkg::CUR_W-1:0] cu, logic [cfs_pkg::CUR_W-1:0] cv,
				logic [cfs_pkg::CUR_W-1:0] cw, logic cval);
			int n;
			longint fe, car, f0, f1, c0, c1, span, imax, total;
			n = 0;
			while (n < cfs_pkg::NUM_BP_SLOTS && car_of(n) != 0) n++;
			if (n == 0) return;
			fe = longint'($signed(fe_in));
			car = car_of(0);
			if (fe > freq_of(0)) begin
				car = car_of(n - 1);
				for (int i = 1; i < n; i++) begin
					if (fe <= freq_of(i)) begin
						f0 = freq_of(i - 1);
						f1 = freq_of(i);
						c0 = car_of(i - 1);
						c1 = car_of(i);
						span = f1 - f0;
						if (span > 0) car = c0 + ((fe - f0) * (c1 - c0)) / span;
						else car = c1;
						break;
					end
				end
			end
			if (car < 0) car = 0;
			total = car;
			if (cval && gain != 0) begin
				imax = mag(cu);
				if (mag(cv) > imax) imax = mag(cv);
				if (mag(cw) > imax) imax = mag(cw);
				total += (longint'(gain) * imax) >>> cfs_pkg::BOOST_SH;
			end
			if (total > 64'd16777215) total = 16777215;
			carrier_q.push_back(total[cfs_pkg::OUT_W-1:0]);
		endfunction

		function void check_result(logic [cfs_pkg::OUT_W-1:0] actual);
			logic [cfs_pkg::OUT_W-1:0] exp_val;
			if (carrier_q.size() == 0) begin
				$error("carrier_freq unexpected result %0d", actual);
				errors++;
				return;
			end
			exp_val = carrier_q.pop_front();
			if (actual !== exp_val) begin
				$error("carrier_freq expected %0d actual %0d", exp_val, actual);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [cfs_pkg::FREQ_W-1:0]    elec_freq;
	logic [cfs_pkg::CUR_W-1:0]     current_u;
	logic [cfs_pkg::CUR_W-1:0]     current_v;
	logic [cfs_pkg::CUR_W-1:0]     current_w;
	logic                          currents_valid;
	logic                          out_valid;
	logic                          out_stall;
	logic [cfs_pkg::OUT_W-1:0]     carrier_freq;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [cfs_pkg::IDX_W-1:0]     cfg_index;
	logic [cfs_pkg::CFG_W-1:0]     cfg_data;

	carrier_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	longint cycles;

	carrier_frequency_schedule_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.elec_freq(elec_freq), .current_u(current_u), .current_v(current_v),
		.current_w(current_w), .currents_valid(currents_valid),
		.out_valid(out_valid), .out_stall(out_stall), .carrier_freq(carrier_freq),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_carrier_frequency_schedule_core: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Both beats are sampled on the values that held just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(elec_freq, current_u, current_v, current_w, currents_valid);
			if (out_valid && !out_stall) sb.check_result(carrier_freq);
		end
	end

	task automatic send_beat(logic [cfs_pkg::FREQ_W-1:0] f, logic [cfs_pkg::CUR_W-1:0] u,
			logic [cfs_pkg::CUR_W-1:0] v, logic [cfs_pkg::CUR_W-1:0] w, logic cv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		elec_freq <= f;
		current_u <= u;
		current_v <= v;
		current_w <= w;
		currents_valid <= cv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.carrier_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [cfs_pkg::IDX_W-1:0] idx,
			logic [cfs_pkg::CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	function automatic logic [cfs_pkg::CFG_W-1:0] pack_bp(longint f, longint c);
		logic [cfs_pkg::CFG_W-1:0] r;
		r[cfs_pkg::FREQ_W-1:0] = f[cfs_pkg::FREQ_W-1:0];
		r[cfs_pkg::CFG_W-1:cfs_pkg::FREQ_W] = c[cfs_pkg::CAR_W-1:0];
		return r;
	endfunction

	// Random table of n live breakpoints; unsorted tables show up now and then.
	task automatic program_random_table();
		int n;
		longint fr[cfs_pkg::NUM_BP_SLOTS];
		logic [cfs_pkg::CFG_W-1:0] d;
		logic [cfs_pkg::GAIN_W-1:0] g;
		n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, cfs_pkg::NUM_BP_SLOTS);
		foreach (fr[i]) fr[i] = longint'($signed(20'($urandom)));
		if ($urandom_range(4) != 0) fr.sort();
		for (int i = 0; i < cfs_pkg::NUM_BP_SLOTS; i++) begin
			d = cfs_pkg::CFG_W'({$urandom, $urandom});
			d[cfs_pkg::FREQ_W-1:0] = fr[i][cfs_pkg::FREQ_W-1:0];
			if (i >= n) d[cfs_pkg::CFG_W-1:cfs_pkg::FREQ_W] = '0;
			else if (d[cfs_pkg::CFG_W-1:cfs_pkg::FREQ_W] == 0) d[cfs_pkg::FREQ_W] = 1'b1;
			write_cfg(cfs_pkg::IDX_W'(i), d);
		end
		case ($urandom_range(3))
			0: g = '0;
			1: g = '1;
			default: g = cfs_pkg::GAIN_W'($urandom);
		endcase
		write_cfg(cfs_pkg::CFG_IDX_GAIN, {25'($urandom), g});
		if ($urandom_range(3) == 0) write_cfg(3'd7, cfs_pkg::CFG_W'({$urandom, $urandom}));
	endtask

	task automatic random_beat();
		logic [cfs_pkg::FREQ_W-1:0] f;
		logic [cfs_pkg::CUR_W-1:0] cur[3];
		longint base;
		if ($urandom_range(1)) begin
			base = sb.freq_of($urandom_range(cfs_pkg::NUM_BP_SLOTS - 1));
			base = base + $urandom_range(4000) - 2000;
			if (base > 524287) base = 524287;
			if (base < -524288) base = -524288;
			f = base[cfs_pkg::FREQ_W-1:0];
		end else begin
			f = cfs_pkg::FREQ_W'($urandom);
		end
		foreach (cur[i]) begin
			case ($urandom_range(7))
				0: cur[i] = 16'h8000;
				1: cur[i] = 16'h7fff;
				2: cur[i] = 16'hffff;
				default: cur[i] = cfs_pkg::CUR_W'($urandom);
			endcase
		end
		send_beat(f, cur[0], cur[1], cur[2], $urandom_range(3) != 0);
	endtask

	initial begin
		sb = new();
		cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		elec_freq = '0;
		current_u = '0;
		current_v = '0;
		current_w = '0;
		currents_valid = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table after reset: beats are taken but give no result.
		send_beat(20'h80000, 16'h8000, 16'h7fff, 16'h0, 1'b1);
		send_beat(20'h7ffff, 16'h0, 16'h0, 16'h0, 1'b0);
		wait_drained();

		write_cfg(3'd0, pack_bp(-400000, 1));
		write_cfg(3'd1, pack_bp(-1000, 2097151));
		write_cfg(3'd2, pack_bp(0, 100));
		write_cfg(3'd3, pack_bp(1000, 50000));
		write_cfg(3'd4, pack_bp(200000, 2097151));
		write_cfg(3'd5, pack_bp(524287, 7));
		write_cfg(cfs_pkg::CFG_IDX_GAIN, 41'hffff);
		send_beat(20'h80000, 16'h0, 16'h0, 16'h0, 1'b0);
		send_beat(cfs_pkg::FREQ_W'(-400000), 16'h8000, 16'h0, 16'h0, 1'b1);
		send_beat(cfs_pkg::FREQ_W'(-399999), 16'h0, 16'h7fff, 16'h0, 1'b1);
		send_beat(20'h0, 16'h0, 16'h0, 16'hffff, 1'b1);
		send_beat(20'd999, 16'h8000, 16'h8000, 16'h8000, 1'b0);
		send_beat(20'd1000, 16'h1234, 16'hedcc, 16'h0040, 1'b1);
		send_beat(20'd150000, 16'h0001, 16'h0002, 16'h0003, 1'b1);
		send_beat(20'h7fffe, 16'h0, 16'h0, 16'h0, 1'b0);
		send_beat(20'h7ffff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
		wait_drained();

		// A zero carrier in the third slot cuts the table to two entries.
		write_cfg(3'd2, pack_bp(5, 0));
		write_cfg(cfs_pkg::CFG_IDX_GAIN, 41'h0);
		send_beat(20'd500, 16'h8000, 16'h0, 16'h0, 1'b1);
		send_beat(20'h7ffff, 16'h0, 16'h0, 16'h0, 1'b1);
		send_beat(cfs_pkg::FREQ_W'(-700), 16'h0, 16'h0, 16'h0, 1'b0);
		wait_drained();

		// Single breakpoint with full-scale carrier; later slots are cut off.
		write_cfg(3'd0, pack_bp(0, 2097151));
		write_cfg(3'd1, pack_bp(10, 0));
		write_cfg(cfs_pkg::CFG_IDX_GAIN, 41'd64);
		send_beat(20'h80000, 16'h8000, 16'h0, 16'h0, 1'b1);
		send_beat(20'h7ffff, 16'h0, 16'h0, 16'h0, 1'b1);
		wait_drained();

		for (int phase = 0; phase < 12; phase++) begin
			program_random_table();
			case (phase % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 82; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 82; end
				default: begin send_idle_pct = 15; stall_pct = 15; end
			endcase
			for (int k = 0; k < 42; k++) random_beat();
			send_idle_pct = 0;
			stall_pct = 0;
			wait_drained();
		end

		if (sb.carrier_q.size() != 0) begin
			$error("carrier_freq %0d expected results never arrived", sb.carrier_q.size());
			sb.errors++;
		end
		if (sb.errors == 0) $display("tb_carrier_frequency_schedule_core: clean");
		else $display("tb_carrier_frequency_schedule_core: errors");
		$finish;
	end
endmodule

// ===== carrier_frequency_schedule_core.f =====
sv/cfs_pkg.sv
sv/cfs_segment.sv
sv/cfs_divider.sv
sv/carrier_frequency_schedule_core.sv
tb/tb_carrier_frequency_schedule_core.sv
